### sv/nbpf_pkg.sv
// ---------------------------------------------------------------------------
// nbpf_pkg: shared types and constants for the nth byte pattern finder
// Register indexes, field widths and the hand-off record between cells.
// ---------------------------------------------------------------------------
package nbpf_pkg;

  // Field widths fixed by the interface
  localparam int unsigned PatW  = 64;
  localparam int unsigned LenW  = 4;
  localparam int unsigned OccW  = 16;
  localparam int unsigned OffW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 2;

  // Configuration register indexes
  typedef enum logic [IdxW-1:0] {
    CFG_PATTERN_BYTES     = 2'd0,
    CFG_PATTERN_LENGTH    = 2'd1,
    CFG_OCCURRENCE_WANTED = 2'd2
  } cfg_idx_e;

  // One window slot as it moves from cell to cell
  typedef struct packed {
    logic             vld;
    logic [ByteW-1:0] data;
  } link_t;

endpackage

### sv/nbpf_if.sv
// ---------------------------------------------------------------------------
// nbpf_in_if / nbpf_out_if: valid/ready channels of the pattern finder
// One request carries one buffer byte; one response carries one search result.
// ---------------------------------------------------------------------------
interface nbpf_in_if;
  logic                       valid;
  logic                       ready;
  logic [nbpf_pkg::ByteW-1:0] data_byte;
  logic                       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nbpf_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [nbpf_pkg::OffW-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

### sv/nth_byte_pattern_finder.sv
// ---------------------------------------------------------------------------
// nth_byte_pattern_finder: start offset of the n-th match of a byte pattern
// Result: registered; shown in the cycle after its deciding byte is taken.
// Throughput: one byte per cycle while results are taken; cells compare in
// parallel; the response register frees itself in the cycle it is taken.
// Reset: asynchronous, active low; clears the window, position, match count
// and response; pattern is zero, length one and occurrence one after reset.
// ---------------------------------------------------------------------------
module nth_byte_pattern_finder #(
  parameter int unsigned MAX_PATTERN = 8,
  parameter int unsigned MAX_BUFFER  = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nbpf_pkg::IdxW-1:0]       cfg_idx_i,
  input  logic [nbpf_pkg::PatW-1:0]       cfg_data_i,
  nbpf_in_if.sink                         req_i,
  nbpf_out_if.source                      res_o
);

  localparam int unsigned PosW  = $clog2(MAX_BUFFER + 1);
  localparam int unsigned CalcW = (PosW > nbpf_pkg::OffW) ? PosW : nbpf_pkg::OffW;
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_BUFFER);
  localparam logic [nbpf_pkg::LenW-1:0] LenMax = nbpf_pkg::LenW'(MAX_PATTERN);

  // Configuration registers
  logic [nbpf_pkg::PatW-1:0] pattern_q;
  logic [nbpf_pkg::LenW-1:0] len_q;
  logic [nbpf_pkg::OccW-1:0] occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= nbpf_pkg::LenW'(1);
      occ_q     <= nbpf_pkg::OccW'(1);
    end else if (cfg_we_i) begin
      case (nbpf_pkg::cfg_idx_e'(cfg_idx_i))
        nbpf_pkg::CFG_PATTERN_BYTES:     pattern_q <= cfg_data_i;
        nbpf_pkg::CFG_PATTERN_LENGTH:    len_q     <= cfg_data_i[nbpf_pkg::LenW-1:0];
        nbpf_pkg::CFG_OCCURRENCE_WANTED: occ_q     <= cfg_data_i[nbpf_pkg::OccW-1:0];
        default: ;
      endcase
    end
  end

  // Length in use, clamped to 1..MAX_PATTERN
  logic [nbpf_pkg::LenW-1:0] len_use;
  always_comb begin
    len_use = len_q;
    if (len_q == '0) begin
      len_use = nbpf_pkg::LenW'(1);
    end else if (len_q > LenMax) begin
      len_use = LenMax;
    end
  end

  // Handshake
  logic res_vld_q;
  logic acc;
  assign req_i.ready = !res_vld_q || res_o.ready;
  assign acc         = req_i.valid && req_i.ready;

  // Row of window cells, newest byte enters cell 0
  nbpf_pkg::link_t        link [MAX_PATTERN+1];
  logic [MAX_PATTERN-1:0] hit;

  assign link[0].vld  = 1'b1;
  assign link[0].data = req_i.data_byte;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    nbpf_cell #(.Slot(j)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (acc),
      .clear_i   (req_i.last_byte),
      .link_i    (link[j]),
      .len_i     (len_use),
      .pattern_i (pattern_q),
      .link_o    (link[j+1]),
      .hit_o     (hit[j])
    );
  end

  // Buffer state
  logic [PosW-1:0]           pos_q, pos_d;
  logic [nbpf_pkg::OccW-1:0] cnt_q, cnt_d, cnt_inc;
  logic                      rep_q, rep_d;
  logic                      match, found_now, emit;
  logic [CalcW-1:0]          off_full;

  assign match     = !rep_q && (pos_q < PosMax) && (&hit);
  assign cnt_inc   = cnt_q + nbpf_pkg::OccW'(cnt_q != '1);
  assign found_now = match && (cnt_inc == occ_q);
  assign emit      = found_now || (req_i.last_byte && !rep_q);
  assign off_full  = CalcW'(pos_q) + CalcW'(1) - CalcW'(len_use);

  always_comb begin
    pos_d = pos_q + PosW'(pos_q < PosMax);
    cnt_d = match ? cnt_inc : cnt_q;
    rep_d = rep_q || found_now;
    if (req_i.last_byte) begin
      pos_d = '0;
      cnt_d = '0;
      rep_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
      rep_q <= 1'b0;
    end else if (acc) begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      rep_q <= rep_d;
    end
  end

  // Response register
  logic                      found_q;
  logic [nbpf_pkg::OffW-1:0] off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (acc && emit) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && emit) begin
      found_q <= found_now;
      off_q   <= found_now ? off_full[nbpf_pkg::OffW-1:0] : '0;
    end
  end

  assign res_o.valid        = res_vld_q;
  assign res_o.found        = found_q;
  assign res_o.match_offset = off_q;

endmodule

### sv/nbpf_cell.sv
// ---------------------------------------------------------------------------
// nbpf_cell: one slot of the byte window
// Holds one byte and its valid flag, passes them on to the next cell on each
// request and compares the incoming byte with its pattern byte.
// ---------------------------------------------------------------------------
module nbpf_cell #(
  parameter int unsigned Slot = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_i,
  input  logic                         clear_i,
  input  nbpf_pkg::link_t              link_i,
  input  logic [nbpf_pkg::LenW-1:0]    len_i,
  input  logic [nbpf_pkg::PatW-1:0]    pattern_i,
  output nbpf_pkg::link_t              link_o,
  output logic                         hit_o
);

  logic                         vld_q, vld_d;
  logic [nbpf_pkg::ByteW-1:0]   data_q;
  logic [nbpf_pkg::LenW-1:0]    pat_sel;
  logic                         in_use;
  logic [nbpf_pkg::ByteW-1:0]   want;

  // Slot j of the window faces pattern byte (len - 1 - j)
  assign in_use  = nbpf_pkg::LenW'(Slot) < len_i;
  assign pat_sel = len_i - nbpf_pkg::LenW'(1) - nbpf_pkg::LenW'(Slot);
  assign want    = pattern_i[{pat_sel[2:0], 3'b000} +: nbpf_pkg::ByteW];

  // Compare against the byte about to enter this slot
  assign hit_o = !in_use || (link_i.vld && (link_i.data == want));

  // Window clears after the final byte of a buffer
  assign vld_d = clear_i ? 1'b0 : link_i.vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (shift_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= link_i.data;
    end
  end

  assign link_o.vld  = vld_q;
  assign link_o.data = data_q;

endmodule

### sv/nbpf_checker.sv
// ---------------------------------------------------------------------------
// nbpf_checker: port-level checks for the nth byte pattern finder
// Watches the response channel and the request ready over time.
// ---------------------------------------------------------------------------
module nbpf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_ready,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic                      res_found,
  input logic [nbpf_pkg::OffW-1:0] res_offset
);

  // A response held back stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> $stable(res_found) && $stable(res_offset))
    else $error("response changed while stalled");

  // Not-found responses carry a zero offset
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_found |-> res_offset == '0)
    else $error("not-found response with non-zero offset");

  // Requests are never refused while the response slot is free or draining
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!res_valid || res_ready) |-> req_ready)
    else $error("request refused with free response slot");

endmodule

bind nth_byte_pattern_finder nbpf_checker u_nbpf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_ready  (req_i.ready),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .res_found  (res_o.found),
  .res_offset (res_o.match_offset)
);

### dv/tb_nth_byte_pattern_finder.sv
// ---------------------------------------------------------------------------
// tb_nth_byte_pattern_finder: self-checking bench for the n-th pattern finder
// Streams byte buffers into the finder and checks every search result against
// a cycle-free predictor of the search or a typed result. A short directed
// table covers the corner cases. Random buffers follow under several register
// settings and idling mixes.
// ---------------------------------------------------------------------------
module tb_nth_byte_pattern_finder;

  localparam int unsigned MaxPattern = 8;
  localparam int unsigned MaxBuffer  = 65536;
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned ItemsPerSetting = 75;
  localparam logic [nbpf_pkg::IdxW-1:0] CfgIdxSpare = 2'd3;

  // Short names for the register indexes used in the directed table
  localparam nbpf_pkg::cfg_idx_e IdxPat = nbpf_pkg::CFG_PATTERN_BYTES;
  localparam nbpf_pkg::cfg_idx_e IdxLen = nbpf_pkg::CFG_PATTERN_LENGTH;
  localparam nbpf_pkg::cfg_idx_e IdxOcc = nbpf_pkg::CFG_OCCURRENCE_WANTED;

  // One search result as seen on the response channel
  typedef struct packed {
    logic                      found;
    logic [nbpf_pkg::OffW-1:0] offset;
  } search_res_t;

  typedef enum logic [0:0] {ROW_CFG, ROW_BYTE} row_kind_e;
  typedef enum logic [1:0] {CHK_PRED, CHK_NONE, CHK_RES} row_check_e;

  // Directed stimulus row: a register write or one byte request
  typedef struct packed {
    row_kind_e                  kind;
    logic [nbpf_pkg::IdxW-1:0]  reg_idx;
    logic [nbpf_pkg::PatW-1:0]  wdata;
    logic [nbpf_pkg::ByteW-1:0] data;
    logic                       last;
    row_check_e                 check;
    search_res_t                want;
  } dir_row_t;

  localparam search_res_t NoRes = '0;

  logic                      clk_i = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we;
  logic [nbpf_pkg::IdxW-1:0] cfg_idx;
  logic [nbpf_pkg::PatW-1:0] cfg_data;

  nbpf_in_if  req_if ();
  nbpf_out_if res_if ();

  nth_byte_pattern_finder #(
    .MAX_PATTERN(MaxPattern),
    .MAX_BUFFER (MaxBuffer)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .res_o     (res_if)
  );

  always #10 clk_i = ~clk_i;

  // Predictor copy of registers and per-buffer search state
  logic [nbpf_pkg::PatW-1:0]  pat_cfg = '0;
  logic [nbpf_pkg::LenW-1:0]  len_cfg = 4'd1;
  logic [nbpf_pkg::OccW-1:0]  occ_cfg = 16'd1;
  logic [nbpf_pkg::ByteW-1:0] hist_win [8];
  logic [16:0]                byte_pos = '0;
  logic [15:0]                match_cnt = '0;
  logic                       reported_flag = 1'b0;

  search_res_t pending_finds [$];
  int          err_cnt = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int unsigned quiet_cycles = 0;

  // Directed table: corner cases with results typed in where obvious
  dir_row_t dir_rows [33] = '{
    '{ROW_BYTE, IdxPat, 64'h0, 8'h00, 1'b0, CHK_RES, '{1'b1, 16'd0}},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b1, CHK_NONE, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b1, CHK_RES, NoRes},
    '{ROW_CFG, IdxPat, 64'h00FF_00FF_00FF_00FF, 8'h00, 1'b0, CHK_NONE, NoRes},
    '{ROW_CFG, IdxLen, 64'd8, 8'h00, 1'b0, CHK_NONE, NoRes},
    '{ROW_CFG, IdxOcc, 64'd2, 8'h00, 1'b0, CHK_NONE, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'h00, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'h00, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'h00, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'h00, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b0, CHK_PRED, NoRes},
    // second overlapping match completes on the final byte
    '{ROW_BYTE, IdxPat, 64'h0, 8'h00, 1'b1, CHK_RES, '{1'b1, 16'd2}},
    // zero length counts as one byte
    '{ROW_CFG, IdxLen, 64'd0, 8'h00, 1'b0, CHK_NONE, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b1, CHK_RES, '{1'b1, 16'd1}},
    // occurrence zero never qualifies
    '{ROW_CFG, IdxOcc, 64'd0, 8'h00, 1'b0, CHK_NONE, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b1, CHK_RES, NoRes},
    // oversized length clamps to eight; buffer shorter than the pattern
    '{ROW_CFG, IdxLen, 64'hF, 8'h00, 1'b0, CHK_NONE, NoRes},
    '{ROW_CFG, IdxOcc, 64'd1, 8'h00, 1'b0, CHK_NONE, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'h00, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b1, CHK_RES, NoRes},
    // write to the unused index must change nothing
    '{ROW_CFG, CfgIdxSpare, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, CHK_NONE, NoRes},
    '{ROW_CFG, IdxLen, 64'd2, 8'h00, 1'b0, CHK_NONE, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'h00, 1'b0, CHK_PRED, NoRes},
    // length changed part way through a buffer
    '{ROW_CFG, IdxLen, 64'd3, 8'h00, 1'b0, CHK_NONE, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'h00, 1'b0, CHK_PRED, NoRes},
    '{ROW_BYTE, IdxPat, 64'h0, 8'hFF, 1'b1, CHK_RES, '{1'b1, 16'd1}}
  };

  // Pattern length actually compared
  function automatic int unsigned used_len();
    if (len_cfg == 0) return 1;
    if (len_cfg > MaxPattern) return MaxPattern;
    return len_cfg;
  endfunction

  // Advance the search by one byte; returns 1 when a result is due
  function automatic bit search_step(input logic [nbpf_pkg::ByteW-1:0] b,
                                     input logic l, output search_res_t res);
    int unsigned plen;
    bit          hit;
    bit          emit;
    plen = used_len();
    emit = 1'b0;
    res  = NoRes;
    for (int i = 7; i > 0; i--) hist_win[i] = hist_win[i-1];
    hist_win[0] = b;
    if (!reported_flag && byte_pos < MaxBuffer && byte_pos + 1 >= plen) begin
      hit = 1'b1;
      for (int k = 0; k < plen; k++) begin
        if (hist_win[plen-1-k] != pat_cfg[8*k +: 8]) hit = 1'b0;
      end
      if (hit) begin
        if (match_cnt != 16'hFFFF) match_cnt++;
        if (match_cnt == occ_cfg) begin
          res.found     = 1'b1;
          res.offset    = nbpf_pkg::OffW'(byte_pos + 1 - plen);
          reported_flag = 1'b1;
          emit          = 1'b1;
        end
      end
    end
    if (byte_pos < MaxBuffer) byte_pos++;
    if (l) begin
      if (!reported_flag) begin
        res  = NoRes;
        emit = 1'b1;
      end
      foreach (hist_win[i]) hist_win[i] = '0;
      byte_pos      = '0;
      match_cnt     = '0;
      reported_flag = 1'b0;
    end
    return emit;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want_v);
    err_cnt++;
  endtask

  // Present one byte request, hold until taken, then book its result
  task automatic send_byte(input logic [nbpf_pkg::ByteW-1:0] b, input logic l,
                           input row_check_e chk, input search_res_t typed);
    search_res_t pred;
    bit          emit;
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.data_byte <= b;
    req_if.last_byte <= l;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    emit = search_step(b, l, pred);
    case (chk)
      CHK_PRED: if (emit) pending_finds.push_back(pred);
      CHK_RES:  pending_finds.push_back(typed);
      default: ;
    endcase
  endtask

  // Sender holds off until every booked result has come back
  task automatic wait_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_finds.size() != 0);
  endtask

  // Quiesce before touching registers; byte-only requests may still be in flight
  task automatic settle();
    wait_results();
    repeat (3) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [nbpf_pkg::IdxW-1:0] idx,
                           input logic [nbpf_pkg::PatW-1:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    case (idx)
      nbpf_pkg::CFG_PATTERN_BYTES:     pat_cfg = v;
      nbpf_pkg::CFG_PATTERN_LENGTH:    len_cfg = v[nbpf_pkg::LenW-1:0];
      nbpf_pkg::CFG_OCCURRENCE_WANTED: occ_cfg = v[nbpf_pkg::OccW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Response side: random back-pressure
  always @(posedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare each taken response with the oldest booked result
  always @(posedge clk_i) begin
    search_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_finds.size() == 0) begin
        report_mismatch("unexpected result",
                        32'({res_if.found, res_if.match_offset}), 32'd0);
      end else begin
        want = pending_finds.pop_front();
        if (res_if.found !== want.found)
          report_mismatch("found", 32'(res_if.found), 32'(want.found));
        if (res_if.match_offset !== want.offset)
          report_mismatch("match_offset", 32'(res_if.match_offset), 32'(want.offset));
      end
    end
  end

  // Watchdog: too long without any request, response or register write
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int           idle_mix  [4];
    int           stall_mix [4];
    int unsigned  sent;
    int unsigned  blen;
    int unsigned  cur;
    int unsigned  r;
    logic [7:0]   b;
    logic [63:0]  pat;
    logic [3:0]   plen;
    logic [15:0]  occ;

    idle_mix  = '{0, 87, 0, 24};
    stall_mix = '{0, 0, 87, 24};
    foreach (hist_win[i]) hist_win[i] = '0;
    req_if.valid     = 1'b0;
    req_if.data_byte = '0;
    req_if.last_byte = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed corner cases
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].wdata);
      end else begin
        send_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].check, dir_rows[i].want);
      end
    end

    // Random buffers under several settings and idling mixes
    for (int m = 0; m < 4; m++) begin
      for (int s = 0; s < 4; s++) begin
        settle();
        idle_pct  = idle_mix[m];
        stall_pct = stall_mix[m];
        if (m == 0 && s == 0) begin
          pat = '1; plen = 4'd8; occ = 16'hFFFF;
        end else if (m == 0 && s == 1) begin
          pat = '0; plen = 4'd1; occ = 16'd1;
        end else begin
          pat = {$urandom, $urandom};
          // small alphabet gives repeats and overlapping matches
          if ($urandom_range(0, 1) == 1) begin
            for (int i = 0; i < 8; i++) begin
              r = $urandom_range(0, 2);
              pat[8*i +: 8] = (r == 0) ? 8'h00 : ((r == 1) ? 8'hFF : 8'hA5);
            end
          end
          plen = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
          r = $urandom_range(0, 9);
          occ = (r < 7) ? 16'($urandom_range(1, 4))
                        : ((r == 7) ? 16'd0 : 16'($urandom_range(0, 65535)));
        end
        cfg_write(nbpf_pkg::CFG_PATTERN_BYTES, pat);
        cfg_write(nbpf_pkg::CFG_PATTERN_LENGTH, 64'(plen));
        cfg_write(nbpf_pkg::CFG_OCCURRENCE_WANTED, 64'(occ));

        sent = 0;
        while (sent < ItemsPerSetting) begin
          blen = ($urandom_range(0, 4) == 0) ? $urandom_range(25, 90) : $urandom_range(1, 24);
          cur  = 0;
          for (int j = 0; j < blen; j++) begin
            // mostly walk the pattern, sometimes restart it or inject noise
            r = $urandom_range(0, 99);
            if (r < 65) begin
              b   = pat_cfg[8*cur +: 8];
              cur = (cur + 1) % used_len();
            end else if (r < 75) begin
              b   = pat_cfg[7:0];
              cur = 1 % used_len();
            end else begin
              b = 8'($urandom);
            end
            if ($urandom_range(0, 49) == 0) wait_results();
            send_byte(b, j == blen - 1, CHK_PRED, NoRes);
            sent++;
          end
        end
      end
    end

    // Drain and allow for a stray late response
    wait_results();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && pending_finds.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
